### hw/rtl/julia_escape_time_pixel_unit_macros.svh
// ----------------------------------------------------------------------------
// julia escape-time pixel unit assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define JETP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define JETP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/jetp_pkg.sv
// ----------------------------------------------------------------------------
// jetp_pkg
// shared types, constants and helpers of the julia escape-time pixel unit
// ----------------------------------------------------------------------------
package jetp_pkg;

  // fixed-point format of coordinates and c
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int MAXIT_W   = 10;

  // default module parameters
  localparam int COORD_BITS_DEF = 12;
  localparam int ITER_LIMIT_DEF = 1023;

  // color divider produces an 8-bit quotient
  localparam int QUOT_BITS = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd5;

  // register reset values
  localparam logic signed [COORD_W-1:0] ORIGIN_REAL_RST = -32'sd644245094;
  localparam logic signed [COORD_W-1:0] ORIGIN_IMAG_RST = -32'sd402653184;
  localparam logic [STEP_W-1:0]         PIXEL_STEP_RST  = 31'd671089;
  localparam logic signed [COORD_W-1:0] C_REAL_RST      = 32'sd0;
  localparam logic signed [COORD_W-1:0] C_IMAG_RST      = 32'sd0;
  localparam logic [MAXIT_W-1:0]        MAX_ITER_RST    = 10'd100;

  // item payloads
  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] iteration_count;
    logic        inside_set;
  } result_t;

  // color band of a finished pixel
  typedef enum logic [2:0] {
    BAND_INSIDE = 3'd0,
    BAND_LOW    = 3'd1,
    BAND_MID    = 3'd2,
    BAND_HIGH   = 3'd3,
    BAND_TOP    = 3'd4
  } band_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic map;
    logic load;
    logic mul;
    logic update;
    logic band;
    logic load_a;
    logic load_b;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic escape;
    logic at_limit;
  } dp_status_t;

  // clamp a wide signed value into the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/jetp_div.sv
// ----------------------------------------------------------------------------
// jetp_div
// restoring divider, one quotient bit per step, 8-bit quotient
// ----------------------------------------------------------------------------
module jetp_div import jetp_pkg::*; #(
  parameter int DIV_W = 10
) (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [DIV_W+QUOT_BITS-1:0] num_i,
  input  logic [DIV_W-1:0]           dvs_i,
  input  logic                       step_i,
  output logic [QUOT_BITS-1:0]       quot_o
);

  localparam int NUM_W = DIV_W + QUOT_BITS;
  localparam int DVS_W = DIV_W + QUOT_BITS - 1;

  logic [NUM_W-1:0]     rem_q;
  logic [DVS_W-1:0]     dvs_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic [NUM_W-1:0]     dvs_ext;
  logic                 fits;

  // trial subtract of the aligned divisor
  assign dvs_ext = NUM_W'(dvs_q);
  assign fits    = (rem_q >= dvs_ext);

  // remainder, shifting divisor and quotient
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q  <= num_i;
      dvs_q  <= DVS_W'(dvs_i) << (QUOT_BITS - 1);
      quot_q <= '0;
    end else if (step_i) begin
      if (fits) begin
        rem_q <= rem_q - dvs_ext;
      end
      dvs_q  <= dvs_q >> 1;
      quot_q <= {quot_q[QUOT_BITS-2:0], fits};
    end
  end

  assign quot_o = quot_q;

endmodule

### hw/rtl/jetp_dp.sv
// ----------------------------------------------------------------------------
// jetp_dp
// datapath: start point mapping, z = z^2 + c iteration, color band math
// ----------------------------------------------------------------------------
module jetp_dp import jetp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
  input  logic                      clk_i,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  pixel_t                    pixel_i,
  input  logic signed [COORD_W-1:0] origin_real_i,
  input  logic signed [COORD_W-1:0] origin_imag_i,
  input  logic [STEP_W-1:0]         pixel_step_i,
  input  logic signed [COORD_W-1:0] c_real_i,
  input  logic signed [COORD_W-1:0] c_imag_i,
  input  logic [MAXIT_W-1:0]        max_iter_i,
  output result_t                   result_o
);

  localparam int MW   = $clog2(ITER_LIMIT + 1);
  localparam int NW   = $clog2(ITER_LIMIT + 2);
  localparam int XW   = MW + 2;
  localparam int NUMW = MW + QUOT_BITS;
  localparam int PW   = COORD_BITS + STEP_W;
  localparam logic [63:0] ESC_LIM = 64'd4 << FRAC_BITS;

  logic [COORD_BITS-1:0]     col_q, row_q;
  logic [MW-1:0]             m_q;
  logic [PW-1:0]             prod_re_q, prod_im_q;
  logic signed [COORD_W-1:0] zr_q, zi_q;
  logic signed [63:0]        zr2_q, zi2_q, zrzi_q;
  logic [NW-1:0]             n_q;
  band_e                     band_q, band_d;
  logic [XW-1:0]             d_q, d_d;
  logic [QUOT_BITS-1:0]      qa_q;
  result_t                   result_q, result_d;

  logic [31:0]               m_full;
  logic [MW-1:0]             m_lim;
  logic signed [63:0]        re_start, im_start;
  logic [63:0]               mag_sum;
  logic                      escape;
  logic signed [63:0]        diff, diff_sh, twice_sh, c_re_ext, c_im_ext;
  logic signed [63:0]        nr_full, ni_full;
  logic [XW-1:0]             nx, mx;
  logic [31:0]               d32, m_less1, num_a32, num_b32;
  logic [NUMW-1:0]           div_num;
  logic [QUOT_BITS-1:0]      quot;

  // iteration limit: zero reads as one, clamp to the build limit
  always_comb begin
    m_full = (max_iter_i == '0) ? 32'd1 : 32'(max_iter_i);
    if (m_full > 32'(ITER_LIMIT)) begin
      m_full = 32'(ITER_LIMIT);
    end
    m_lim = MW'(m_full);
  end

  // start point: origin plus index times step, saturated
  assign re_start = $signed(64'(prod_re_q)) + 64'(origin_real_i);
  assign im_start = $signed(64'(prod_im_q)) + 64'(origin_imag_i);

  // escape test on |z|^2 in Q8.56
  assign mag_sum = $unsigned(zr2_q) + $unsigned(zi2_q);
  assign escape  = ((mag_sum >> FRAC_BITS) >= ESC_LIM);

  // next z, floor shifts back to Q4.28 then add c
  assign c_re_ext = 64'(c_real_i);
  assign c_im_ext = 64'(c_imag_i);
  assign diff     = zr2_q - zi2_q;
  assign diff_sh  = diff >>> FRAC_BITS;
  assign twice_sh = zrzi_q >>> (FRAC_BITS - 1);
  assign nr_full  = diff_sh + c_re_ext;
  assign ni_full  = twice_sh + c_im_ext;

  assign status_o.escape   = escape;
  assign status_o.at_limit = (n_q == NW'(m_q));

  // pixel capture, mapping and iteration registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= COORD_BITS'(pixel_i.column);
      row_q <= COORD_BITS'(pixel_i.row);
      m_q   <= m_lim;
    end
    if (cmd_i.map) begin
      prod_re_q <= PW'(col_q) * PW'(pixel_step_i);
      prod_im_q <= PW'(row_q) * PW'(pixel_step_i);
    end
    if (cmd_i.load) begin
      zr_q <= sat32(re_start);
      zi_q <= sat32(im_start);
      n_q  <= '0;
    end
    if (cmd_i.mul) begin
      zr2_q  <= 64'(zr_q) * 64'(zr_q);
      zi2_q  <= 64'(zi_q) * 64'(zi_q);
      zrzi_q <= 64'(zr_q) * 64'(zi_q);
    end
    if (cmd_i.update && !escape) begin
      zr_q <= sat32(nr_full);
      zi_q <= sat32(ni_full);
      n_q  <= n_q + 1'b1;
    end
  end

  // band selection against m/4, m/2 and 3m/4
  always_comb begin
    nx = XW'(n_q);
    mx = XW'(m_q);
    priority if (nx > mx) begin
      band_d = BAND_INSIDE;
      d_d    = '0;
    end else if (nx <= (mx >> 2)) begin
      band_d = BAND_LOW;
      d_d    = nx;
    end else if (nx <= (mx >> 1)) begin
      band_d = BAND_MID;
      d_d    = (nx << 2) - mx;
    end else if (nx <= ((mx + (mx << 1)) >> 2)) begin
      band_d = BAND_HIGH;
      d_d    = (nx << 1) - mx;
    end else begin
      band_d = BAND_TOP;
      d_d    = (nx << 2) - mx - (mx << 1);
    end
  end

  // numerators of the two color divisions, ceiling terms add m-1
  always_comb begin
    d32     = 32'(d_q);
    m_less1 = 32'(m_q) - 32'd1;
    unique case (band_q)
      BAND_LOW:    num_a32 = d32 * 32'd508;
      BAND_MID:    num_a32 = d32 * 32'd255;
      BAND_HIGH:   num_a32 = d32 * 32'd110 + m_less1;
      BAND_TOP:    num_a32 = d32 * 32'd255 + m_less1;
      BAND_INSIDE: num_a32 = 32'd0;
      default:     num_a32 = 32'd0;
    endcase
    unique case (band_q)
      BAND_HIGH:   num_b32 = d32 * 32'd510 + m_less1;
      BAND_TOP:    num_b32 = d32 * 32'd200 + m_less1;
      BAND_LOW,
      BAND_MID,
      BAND_INSIDE: num_b32 = 32'd0;
      default:     num_b32 = 32'd0;
    endcase
    div_num = cmd_i.load_b ? NUMW'(num_b32) : NUMW'(num_a32);
  end

  jetp_div #(
    .DIV_W (MW)
  ) u_div (
    .clk_i  (clk_i),
    .load_i (cmd_i.load_a | cmd_i.load_b),
    .num_i  (div_num),
    .dvs_i  (m_q),
    .step_i (cmd_i.div_step),
    .quot_o (quot)
  );

  // final colors from the two quotients
  always_comb begin
    result_d.iteration_count = 11'(n_q);
    result_d.inside_set      = 1'b0;
    result_d.red             = 8'd0;
    result_d.green           = 8'd0;
    result_d.blue            = 8'd0;
    unique case (band_q)
      BAND_INSIDE: begin
        result_d.inside_set = 1'b1;
      end
      BAND_LOW: begin
        result_d.blue = 8'd128 + qa_q;
      end
      BAND_MID: begin
        result_d.red   = qa_q;
        result_d.green = qa_q;
        result_d.blue  = 8'd255;
      end
      BAND_HIGH: begin
        result_d.red   = 8'd255;
        result_d.green = 8'd255 - qa_q;
        result_d.blue  = 8'd255 - quot;
      end
      BAND_TOP: begin
        result_d.red   = 8'd255 - qa_q;
        result_d.green = 8'd200 - quot;
      end
      default: begin
        result_d.inside_set = 1'b0;
      end
    endcase
  end

  // band, first quotient and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.band) begin
      band_q <= band_d;
      d_q    <= d_d;
    end
    if (cmd_i.load_b) begin
      qa_q <= quot;
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

### hw/rtl/jetp_ctrl.sv
// ----------------------------------------------------------------------------
// jetp_ctrl
// sequencer of the pixel unit: map, iterate, band, divide, finish
// ----------------------------------------------------------------------------
module jetp_ctrl import jetp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       done_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MAP    = 11'b000_0000_0010,
    S_LOAD   = 11'b000_0000_0100,
    S_MUL    = 11'b000_0000_1000,
    S_UPD    = 11'b000_0001_0000,
    S_BAND   = 11'b000_0010_0000,
    S_LOAD_A = 11'b000_0100_0000,
    S_DIV_A  = 11'b000_1000_0000,
    S_LOAD_B = 11'b001_0000_0000,
    S_DIV_B  = 11'b010_0000_0000,
    S_FINISH = 11'b100_0000_0000
  } state_e;

  localparam int CW = $clog2(QUOT_BITS);
  localparam logic [CW-1:0] STEP_LAST = CW'(QUOT_BITS - 1);

  state_e        state_q, state_d;
  logic [CW-1:0] step_q, step_d;
  logic          done_q, done_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = (status_i.escape || status_i.at_limit) ? S_BAND : S_MUL;
      end
      S_BAND: begin
        cmd_o.band = 1'b1;
        state_d    = S_LOAD_A;
      end
      S_LOAD_A: begin
        cmd_o.load_a = 1'b1;
        step_d       = '0;
        state_d      = S_DIV_A;
      end
      S_DIV_A: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = S_LOAD_B;
        end
      end
      S_LOAD_B: begin
        cmd_o.load_b = 1'b1;
        step_d       = '0;
        state_d      = S_DIV_B;
      end
      S_DIV_B: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result strobe follows the finish cycle
  assign done_d = (state_q == S_FINISH);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

### hw/rtl/julia_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit
// escape-time color of one julia set pixel per item, fixed point Q4.28
// ----------------------------------------------------------------------------
// usage:
//   item in: drive pixel_i with column and row and raise start; the item is
//   taken on a clock edge where start is high and busy is low. busy stays
//   high until the result is built.
//   result out: done_o pulses for one cycle with result_o valid in that
//   cycle. there is no back-pressure; the receiver must take it then.
//   config: cfg_valid_i with cfg_index_i and cfg_data_i writes a register
//   (origin real/imag, pixel step, c real/imag, max iterations); cfg_ready_o
//   is always high. write only while busy is low and no result is pending.
//   steps: after accept, mapping runs in the map and load states; each
//   iteration runs a multiply state (three 32x32 multiplies), then an update
//   state (saturating update and escape compare), and a pixel inside the set
//   performs limit + 1 iterations. the color band then costs a band state,
//   two divisions by the limit on one shared restoring divider and a finish
//   state.
//   a new item may be accepted in the cycle done_o is high.
//   reset: configuration registers return to their defaults, the unit goes
//   idle and no result is pending.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit import jetp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pixel_t                pixel_i,
  output logic                  done_o,
  output result_t               result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic signed [COORD_W-1:0] origin_real_q, origin_imag_q, c_real_q, c_imag_q;
  logic [STEP_W-1:0]         pixel_step_q;
  logic [MAXIT_W-1:0]        max_iter_q;
  dp_cmd_t                   cmd;
  dp_status_t                status;

  // configuration registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q <= ORIGIN_REAL_RST;
      origin_imag_q <= ORIGIN_IMAG_RST;
      pixel_step_q  <= PIXEL_STEP_RST;
      c_real_q      <= C_REAL_RST;
      c_imag_q      <= C_IMAG_RST;
      max_iter_q    <= MAX_ITER_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_REAL: origin_real_q <= cfg_data_i;
        CFG_ORIGIN_IMAG: origin_imag_q <= cfg_data_i;
        CFG_PIXEL_STEP:  pixel_step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_C_REAL:      c_real_q      <= cfg_data_i;
        CFG_C_IMAG:      c_imag_q      <= cfg_data_i;
        CFG_MAX_ITER:    max_iter_q    <= cfg_data_i[MAXIT_W-1:0];
        default: begin
          max_iter_q <= max_iter_q;
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  jetp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd),
    .done_o   (done_o)
  );

  jetp_dp #(
    .COORD_BITS (COORD_BITS),
    .ITER_LIMIT (ITER_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .pixel_i       (pixel_i),
    .origin_real_i (origin_real_q),
    .origin_imag_i (origin_imag_q),
    .pixel_step_i  (pixel_step_q),
    .c_real_i      (c_real_q),
    .c_imag_i      (c_imag_q),
    .max_iter_i    (max_iter_q),
    .result_o      (result_o)
  );

endmodule

### hw/rtl/jetp_port_chk.sv
// ----------------------------------------------------------------------------
// jetp_port_chk
// port-level checks of the pixel unit, bound to the top level
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_unit_macros.svh"

module jetp_port_chk import jetp_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // an accepted item makes the unit busy
  `JETP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "busy not raised after start")

  // the result strobe comes exactly when busy drops
  `JETP_ASSERT_NOW(a_done_at_end, clk_i, rst_ni, done_o, $fell(busy), "done without end of work")
  `JETP_ASSERT_NOW(a_end_gives_done, clk_i, rst_ni, $fell(busy), done_o, "work ended without result")

  // inside pixels are black, full blue only in the two cool bands
  `JETP_ASSERT_NOW(a_inside_black, clk_i, rst_ni, done_o && result_o.inside_set, (result_o.red == 8'd0) && (result_o.green == 8'd0) && (result_o.blue == 8'd0), "inside pixel not black")
  `JETP_ASSERT_NOW(a_blue_gray, clk_i, rst_ni, done_o && (result_o.blue == 8'd255), result_o.red == result_o.green, "full blue with red and green apart")

endmodule

bind julia_escape_time_pixel_unit jetp_port_chk u_port_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

### verif/julia_escape_time_pixel_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit_tb
// self-checking bench: a directed table of pixels and register writes, then
// random phases of register settings and pixel items, each result compared
// against a table value or an in-bench fixed-point escape-time color model
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit_tb import jetp_pkg::*;;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 800;
  // escape radius squared, 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_MAG = 64'h0400_0000_0000_0000;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                px;
    bit                    typed;
    result_t               want;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  pixel_t                pixel_i     = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_ready_o;

  // register copies seen by the color model
  longint          cur_origin_re = ORIGIN_REAL_RST;
  longint          cur_origin_im = ORIGIN_IMAG_RST;
  longint          cur_step      = PIXEL_STEP_RST;
  longint          cur_c_re      = C_REAL_RST;
  longint          cur_c_im      = C_IMAG_RST;
  int unsigned     cur_max_iter  = MAX_ITER_RST;

  result_t  pending_colors [$];
  dir_row_t dir_table [$];
  int       mismatches = 0;
  int       burst_left = 1;

  julia_escape_time_pixel_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_i     (pixel_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clamp to the signed 32-bit coordinate range
  function automatic longint clamp_q428(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // escape-time count and band color of one pixel under current registers
  function automatic result_t julia_pixel_color(pixel_t px);
    longint      zr, zi, zr2, zi2;
    logic [63:0] mag;
    int unsigned m, n, d, r, g, b;
    bit          in_set;
    result_t     res;
    zr = clamp_q428(cur_origin_re + longint'(px.column) * cur_step);
    zi = clamp_q428(cur_origin_im + longint'(px.row) * cur_step);
    m = (cur_max_iter == 0) ? 1 : cur_max_iter;
    if (m > ITER_LIMIT_DEF) m = ITER_LIMIT_DEF;
    n = 0;
    r = 0;
    g = 0;
    b = 0;
    in_set = 1'b0;
    // iterate z = z^2 + c with exact squares and floor shifts
    while (n <= m) begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      mag = zr2 + zi2;
      if (mag >= ESCAPE_MAG) break;
      zi = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + cur_c_im);
      zr = clamp_q428(((zr2 - zi2) >>> FRAC_BITS) + cur_c_re);
      n++;
    end
    // four color bands split at m/4, m/2 and 3m/4
    if (n > m) begin
      in_set = 1'b1;
    end else if (n <= m / 4) begin
      b = 128 + (508 * n) / m;
    end else if (n <= m / 2) begin
      r = ((4 * n - m) * 255) / m;
      g = r;
      b = 255;
    end else if (n <= (m * 3) / 4) begin
      d = 2 * n - m;
      r = 255;
      g = 255 - (d * 110 + m - 1) / m;
      b = 255 - (d * 510 + m - 1) / m;
    end else begin
      d = 4 * n - 3 * m;
      r = 255 - (d * 255 + m - 1) / m;
      g = 200 - (d * 200 + m - 1) / m;
    end
    res.red             = r[7:0];
    res.green           = g[7:0];
    res.blue            = b[7:0];
    res.iteration_count = n[10:0];
    res.inside_set      = in_set;
    return res;
  endfunction

  // directed table builders
  function automatic void tbl_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t row_e;
    row_e = '{kind: ROW_WRITE, idx: idx, data: data, px: '0, typed: 1'b0, want: '0};
    dir_table.push_back(row_e);
  endfunction

  function automatic void tbl_pixel(int col, int rw);
    dir_row_t row_e;
    row_e = '{kind: ROW_PIXEL, idx: '0, data: '0, px: {12'(col), 12'(rw)}, typed: 1'b0,
              want: '0};
    dir_table.push_back(row_e);
  endfunction

  function automatic void tbl_known(int col, int rw, result_t want);
    dir_row_t row_e;
    row_e = '{kind: ROW_PIXEL, idx: '0, data: '0, px: {12'(col), 12'(rw)}, typed: 1'b1,
              want: want};
    dir_table.push_back(row_e);
  endfunction

  // one register write, model copy follows the accepted write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ORIGIN_REAL: cur_origin_re = longint'(signed'(data));
      CFG_ORIGIN_IMAG: cur_origin_im = longint'(signed'(data));
      CFG_PIXEL_STEP:  cur_step      = longint'(data[STEP_W-1:0]);
      CFG_C_REAL:      cur_c_re      = longint'(signed'(data));
      CFG_C_IMAG:      cur_c_im      = longint'(signed'(data));
      CFG_MAX_ITER:    cur_max_iter  = data[MAXIT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one pixel item; start stays high inside a burst, bursts end in a gap
  task automatic send_pixel(pixel_t px, bit typed, result_t want);
    int gap;
    @(negedge clk_i);
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
    pending_colors.push_back(typed ? want : julia_pixel_color(px));
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      gap = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 80);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // drop start and wait for every outstanding pixel to come back
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_colors.size() != 0 || busy) @(posedge clk_i);
  endtask

  // result check against the oldest outstanding pixel
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_colors.size() == 0) begin
        $error("result with no pixel outstanding");
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        if (result_o.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, result_o.red);
          mismatches++;
        end
        if (result_o.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, result_o.green);
          mismatches++;
        end
        if (result_o.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, result_o.blue);
          mismatches++;
        end
        if (result_o.iteration_count !== want.iteration_count) begin
          $error("iteration_count: expected %0d, got %0d", want.iteration_count,
                 result_o.iteration_count);
          mismatches++;
        end
        if (result_o.inside_set !== want.inside_set) begin
          $error("inside_set: expected %0d, got %0d", want.inside_set, result_o.inside_set);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pixel_t      px;
    longint      half_span;
    int unsigned step_val;
    int          phase;
    int          random_items;
    int          n_items;
    bit          big;
    bit          noisy;

    // reset defaults: far corner escapes before the first step
    tbl_known(0, 0, {8'd0, 8'd0, 8'd128, 11'd0, 1'b0});
    tbl_pixel(4095, 4095);
    tbl_pixel(960, 600);
    tbl_pixel(2048, 1);
    tbl_pixel(1, 2048);
    // z0 = 0 with c = 0 never escapes
    tbl_write(CFG_ORIGIN_REAL, 32'd0);
    tbl_write(CFG_ORIGIN_IMAG, 32'd0);
    tbl_known(0, 0, {8'd0, 8'd0, 8'd0, 11'd101, 1'b1});
    // zero limit behaves as a limit of one
    tbl_write(CFG_MAX_ITER, 32'd0);
    tbl_known(0, 0, {8'd0, 8'd0, 8'd0, 11'd2, 1'b1});
    // limit of one, escape after the first step lands in the top band
    tbl_write(CFG_MAX_ITER, 32'd1);
    tbl_write(CFG_C_REAL, 32'h3000_0000);
    tbl_pixel(0, 0);
    // extreme c, largest limit
    tbl_write(CFG_C_REAL, 32'h7fff_ffff);
    tbl_write(CFG_C_IMAG, 32'h8000_0000);
    tbl_write(CFG_MAX_ITER, 32'd1023);
    tbl_pixel(0, 0);
    tbl_write(CFG_C_REAL, 32'd0);
    tbl_write(CFG_C_IMAG, 32'd0);
    tbl_known(0, 0, {8'd0, 8'd0, 8'd0, 11'd1024, 1'b1});
    // start point saturation, top bit of the step is dropped
    tbl_write(CFG_ORIGIN_REAL, 32'h7fff_ffff);
    tbl_write(CFG_ORIGIN_IMAG, 32'h8000_0000);
    tbl_write(CFG_PIXEL_STEP, 32'hffff_ffff);
    tbl_known(0, 0, {8'd0, 8'd0, 8'd128, 11'd0, 1'b0});
    tbl_pixel(4095, 4095);
    tbl_pixel(4095, 0);
    // writes past the register map change nothing
    tbl_write(CFG_SPARE_LO, 32'hffff_ffff);
    tbl_write(CFG_SPARE_HI, 32'hffff_ffff);
    tbl_write(CFG_ORIGIN_REAL, ORIGIN_REAL_RST);
    tbl_write(CFG_ORIGIN_IMAG, ORIGIN_IMAG_RST);
    tbl_write(CFG_PIXEL_STEP, 32'd1);
    tbl_pixel(4095, 4095);
    // classic julia constant over the default window
    tbl_write(CFG_PIXEL_STEP, PIXEL_STEP_RST);
    tbl_write(CFG_C_REAL, -32'sd214748365);
    tbl_write(CFG_C_IMAG, 32'sd41875931);
    tbl_write(CFG_MAX_ITER, 32'd64);
    tbl_pixel(960, 600);
    tbl_pixel(800, 500);
    tbl_pixel(1100, 650);
    tbl_pixel(700, 700);
    tbl_pixel(1200, 400);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(dir_table[i].idx, dir_table[i].data);
      end else begin
        send_pixel(dir_table[i].px, dir_table[i].typed, dir_table[i].want);
      end
    end

    // random phases: mostly windows over the set with small limits,
    // some phases of raw register noise, a few with large limits
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      big   = (phase % 6 == 5);
      noisy = (phase % 4 == 2);
      wait_idle();
      if (noisy) begin
        cfg_write(CFG_ORIGIN_REAL, $urandom);
        cfg_write(CFG_C_IMAG, $urandom);
        cfg_write(CFG_PIXEL_STEP, $urandom);
        cfg_write(CFG_C_REAL, $urandom);
        cfg_write(CFG_ORIGIN_IMAG, $urandom);
        cfg_write(CFG_MAX_ITER, ($urandom & 32'hffff_fc00) | $urandom_range(0, 127));
        cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
      end else begin
        // window centered near zero, width about one to eight units
        step_val  = $urandom_range(1 << 16, 1 << 19);
        half_span = longint'(step_val) << 11;
        cfg_write(CFG_PIXEL_STEP, step_val);
        cfg_write(CFG_ORIGIN_REAL,
                  32'(longint'($urandom_range(0, 1 << 28)) - (1 << 27) - half_span));
        cfg_write(CFG_ORIGIN_IMAG,
                  32'(longint'($urandom_range(0, 1 << 28)) - (1 << 27) - half_span));
        cfg_write(CFG_C_REAL, 32'(longint'($urandom_range(0, 1 << 29)) - (1 << 28)));
        cfg_write(CFG_C_IMAG, 32'(longint'($urandom_range(0, 1 << 29)) - (1 << 28)));
        cfg_write(CFG_MAX_ITER, big ? $urandom_range(256, 1023) : $urandom_range(0, 100));
      end
      n_items = big ? 6 : 40;
      repeat (n_items) begin
        px.column = 12'($urandom_range(0, 4095));
        px.row    = 12'($urandom_range(0, 4095));
        send_pixel(px, 1'b0, '0);
      end
      random_items += n_items;
      phase++;
    end

    // drain, then a quiet stretch to catch stray results
    wait_idle();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run time guard
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
